// ===== rtl/sip_pkg.sv =====
// shared types, constants and the round function of the keyed mac
package sip_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned NB_W   = 4;
	localparam int unsigned ADDR_W = 5;

	localparam logic [WORD_W-1:0] INIT_A = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] INIT_B = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] INIT_C = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] INIT_D = 64'h7465646279746573;

	localparam logic [LEN_W-1:0] WIDE_MARK   = 8'hee;
	localparam logic [LEN_W-1:0] NARROW_MARK = 8'hff;
	localparam logic [LEN_W-1:0] SECOND_MARK = 8'hdd;

	// register index, taken from paddr[4:3]
	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_WIDE_TAG = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} lanes_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take the input word, seed when no message is open
		logic round;      // one round on the lanes
		logic xor_a_w;    // close a compression: a ^= word
		logic load_len;   // start the length block after a full last word
		logic mark_c;     // finalization mark into lane c
		logic wide;       // mark select and tag width of this message
		logic flip_b;     // second tag word mark into lane b
		logic emit;       // tag goes to the output register
		logic emit_index;
		logic emit_last;
	} sip_cmd_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned s);
		rotl = (x << s) | (x >> (WORD_W - s));
	endfunction

	function automatic lanes_t sip_round(input lanes_t l);
		lanes_t r;
		r = l;
		r.a = r.a + r.b;
		r.b = rotl(r.b, 13) ^ r.a;
		r.a = rotl(r.a, 32);
		r.c = r.c + r.d;
		r.d = rotl(r.d, 16) ^ r.c;
		r.a = r.a + r.d;
		r.d = rotl(r.d, 21) ^ r.a;
		r.c = r.c + r.b;
		r.b = rotl(r.b, 17) ^ r.c;
		r.c = rotl(r.c, 32);
		sip_round = r;
	endfunction

endpackage

// ===== rtl/siphash_keyed_mac.sv =====
// top level: keyed siphash tag over a word stream, apb registers, output register
// after the last transfer: compression rounds, a length block compression when the last word
//   holds eight bytes, then finalization rounds, then the tag word into the output register
// input is taken only when idle: the single round unit finishes each word's compression first
// second tag word in wide mode follows the first after a lane b mark and its own finalization rounds
// reset: key cleared, wide tag on, no message open, output register empty
module siphash_keyed_mac #(
	parameter int unsigned COMPRESS_ROUNDS = 2,
	parameter int unsigned FINAL_ROUNDS    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sip_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	// message words
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [71:0]                 s_tdata,  // msg_word[63:0], valid_bytes[67:64], zero
	input  logic                        s_tlast,
	// tag words
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata,  // tag_word[63:0]
	output logic                        m_tuser,  // tag_index
	output logic                        m_tlast
);

	logic [63:0]       key_low_q;
	logic [63:0]       key_high_q;
	logic              wide_tag_q;
	logic              wr_en;
	logic              out_busy;
	logic [63:0]       tag;
	logic              accept;
	sip_pkg::sip_cmd_t cmd;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			wide_tag_q <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				sip_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				sip_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				sip_pkg::REG_WIDE_TAG: wide_tag_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			sip_pkg::REG_KEY_LOW:  prdata = key_low_q;
			sip_pkg::REG_KEY_HIGH: prdata = key_high_q;
			sip_pkg::REG_WIDE_TAG: prdata = {63'd0, wide_tag_q};
			default:               prdata = '0;
		endcase
	end

	assign accept   = s_tvalid && s_tready;
	assign out_busy = m_tvalid_q && !m_tready;

	sip_ctrl #(
		.COMPRESS_ROUNDS (COMPRESS_ROUNDS),
		.FINAL_ROUNDS    (FINAL_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_full  (s_tdata[67]),
		.wide_tag (wide_tag_q),
		.out_busy (out_busy),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	sip_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_word    (s_tdata[63:0]),
		.valid_bytes (s_tdata[67:64]),
		.is_last     (s_tlast),
		.key_low     (key_low_q),
		.key_high    (key_high_q),
		.wide_tag    (wide_tag_q),
		.tag         (tag)
	);

	// output register, refilled as soon as the waiting transfer goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= tag;
			m_tuser_q <= cmd.emit_index;
			m_tlast_q <= cmd.emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load == accept)
		else $error("datapath load out of step with input transfer");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !cmd.emit)
		else $error("input taken while a tag is emitted");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted tag not presented");

endmodule

// ===== rtl/sip_dp.sv =====
// datapath: four lanes, shared round unit, length count and padding
module sip_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sip_pkg::sip_cmd_t             cmd,
	input  logic [sip_pkg::WORD_W-1:0]    msg_word,
	input  logic [sip_pkg::NB_W-1:0]      valid_bytes,
	input  logic                          is_last,
	input  logic [sip_pkg::WORD_W-1:0]    key_low,
	input  logic [sip_pkg::WORD_W-1:0]    key_high,
	input  logic                          wide_tag,
	output logic [sip_pkg::WORD_W-1:0]    tag
);

	sip_pkg::lanes_t                    lanes_q;
	sip_pkg::lanes_t                    lanes_d;
	sip_pkg::lanes_t                    base;
	sip_pkg::lanes_t                    rnd;
	logic [sip_pkg::WORD_W-1:0]         w_q;
	logic [sip_pkg::WORD_W-1:0]         len_blk_q;
	logic [sip_pkg::LEN_W-1:0]          len_q;
	logic                               in_msg_q;
	logic [sip_pkg::LEN_W-1:0]          len_new;
	logic [sip_pkg::LEN_W-1:0]          len_add;
	logic [sip_pkg::WORD_W-1:0]         blk;
	logic [sip_pkg::WORD_W-1:0]         w_in;
	logic                               partial;

	// short last word carries its own length block
	assign partial = is_last && !valid_bytes[3];
	assign len_add = partial ? {5'd0, valid_bytes[2:0]} : 8'd8;
	assign len_new = (in_msg_q ? len_q : '0) + len_add;

	always_comb begin
		blk = '0;
		for (int i = 0; i < 7; i++) begin
			if (i < int'(valid_bytes[2:0]))
				blk[8*i +: 8] = msg_word[8*i +: 8];
		end
		blk[63:56] = len_new;
	end

	assign w_in = partial ? blk : msg_word;

	always_comb begin
		if (in_msg_q) begin
			base = lanes_q;
		end else begin
			base.a = sip_pkg::INIT_A ^ key_low;
			base.b = sip_pkg::INIT_B ^ key_high ^ {56'd0, (wide_tag ? sip_pkg::WIDE_MARK : 8'd0)};
			base.c = sip_pkg::INIT_C ^ key_low;
			base.d = sip_pkg::INIT_D ^ key_high;
		end
	end

	assign rnd = sip_pkg::sip_round(lanes_q);

	always_comb begin
		lanes_d = lanes_q;
		if (cmd.load) begin
			lanes_d   = base;
			lanes_d.d = base.d ^ w_in;
		end else if (cmd.round) begin
			lanes_d = rnd;
			if (cmd.xor_a_w)
				lanes_d.a = rnd.a ^ w_q;
			if (cmd.load_len)
				lanes_d.d = rnd.d ^ len_blk_q;
			if (cmd.mark_c)
				lanes_d.c = rnd.c ^ {56'd0, (cmd.wide ? sip_pkg::WIDE_MARK : sip_pkg::NARROW_MARK)};
		end else if (cmd.flip_b) begin
			lanes_d.b = lanes_q.b ^ {56'd0, sip_pkg::SECOND_MARK};
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		if (cmd.load) begin
			w_q       <= w_in;
			len_q     <= len_new;
			len_blk_q <= {len_new, 56'd0};
		end else if (cmd.round && cmd.load_len) begin
			w_q <= len_blk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (cmd.load) begin
			in_msg_q <= !is_last;
		end
	end

	assign tag = lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;

endmodule

// ===== rtl/sip_ctrl.sv =====
// controller: sequences compression, finalization and tag output
module sip_ctrl #(
	parameter int unsigned COMPRESS_ROUNDS = 2,
	parameter int unsigned FINAL_ROUNDS    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic              in_full,
	input  logic              wide_tag,
	input  logic              out_busy,
	output logic              in_ready,
	output sip_pkg::sip_cmd_t cmd
);

	localparam int unsigned MAXR  = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
	localparam int unsigned CNT_W = $clog2(MAXR + 1);
	localparam logic [CNT_W-1:0] C_END = CNT_W'(COMPRESS_ROUNDS - 1);
	localparam logic [CNT_W-1:0] F_END = CNT_W'(FINAL_ROUNDS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_COMP = 4'b0010,
		S_FIN  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             last_q, last_d;
	logic             len_pend_q, len_pend_d;
	logic             wide_q, wide_d;
	logic             second_q, second_d;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		last_d     = last_q;
		len_pend_d = len_pend_q;
		wide_d     = wide_q;
		second_d   = second_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.wide       = wide_q;
		cmd.emit_index = second_q;
		cmd.emit_last  = !wide_q || second_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					last_d     = in_last;
					len_pend_d = in_last && in_full;
					wide_d     = wide_tag;
					cnt_d      = '0;
					state_d    = S_COMP;
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				if (cnt_q == C_END) begin
					cmd.xor_a_w = 1'b1;
					cnt_d       = '0;
					if (!last_q) begin
						state_d = S_IDLE;
					end else if (len_pend_q) begin
						cmd.load_len = 1'b1;
						len_pend_d   = 1'b0;
					end else begin
						cmd.mark_c = 1'b1;
						state_d    = S_FIN;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_FIN: begin
				cmd.round = 1'b1;
				if (cnt_q == F_END) begin
					cnt_d   = '0;
					state_d = S_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					if (wide_q && !second_q) begin
						cmd.flip_b = 1'b1;
						second_d   = 1'b1;
						state_d    = S_FIN;
					end else begin
						second_d = 1'b0;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			last_q     <= 1'b0;
			len_pend_q <= 1'b0;
			wide_q     <= 1'b0;
			second_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			last_q     <= last_d;
			len_pend_q <= len_pend_d;
			wide_q     <= wide_d;
			second_q   <= second_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_busy)
		else $error("tag emitted into a full output register");

	a_second_wide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(second_q) |-> wide_q)
		else $error("second tag word in narrow mode");

	a_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_len |-> last_q)
		else $error("length block outside a last word");

	a_flip_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flip_b |=> state_q == S_FIN)
		else $error("second tag word not finalized");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the keyed siphash tag block
`timescale 1ns / 1ps

module tb;

	localparam int COMPRESS_ROUNDS = 2;
	localparam int FINAL_ROUNDS    = 4;
	localparam int ITEM_TARGET     = 1100;
	localparam int IDLE_LIMIT      = 4000;
	localparam int SETTLE_CYCLES   = 16;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

	// tag words owed by the block, worked out from accepted message words
	class mac_scoreboard;
		typedef struct {
			logic [63:0] word;
			logic        index;
			logic        last;
		} tag_t;

		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic        wide;
		logic [63:0] va, vb, vc, vd;
		logic [7:0]  len;
		logic        open;
		tag_t        tag_q[$];
		int          mismatches;

		function new();
			key_lo     = '0;
			key_hi     = '0;
			wide       = 1'b1;
			va         = '0;
			vb         = '0;
			vc         = '0;
			vd         = '0;
			len        = '0;
			open       = 1'b0;
			mismatches = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				sip_pkg::REG_KEY_LOW:  key_lo = value;
				sip_pkg::REG_KEY_HIGH: key_hi = value;
				sip_pkg::REG_WIDE_TAG: wide = value[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] rol(logic [63:0] x, int s);
			return (x << s) | (x >> (64 - s));
		endfunction

		function void mix_round();
			va = va + vb;
			vb = rol(vb, 13) ^ va;
			va = rol(va, 32);
			vc = vc + vd;
			vd = rol(vd, 16) ^ vc;
			va = va + vd;
			vd = rol(vd, 21) ^ va;
			vc = vc + vb;
			vb = rol(vb, 17) ^ vc;
			vc = rol(vc, 32);
		endfunction

		function void absorb(logic [63:0] w);
			vd ^= w;
			for (int i = 0; i < COMPRESS_ROUNDS; i++)
				mix_round();
			va ^= w;
		endfunction

		function logic [63:0] squeeze();
			for (int i = 0; i < FINAL_ROUNDS; i++)
				mix_round();
			return va ^ vb ^ vc ^ vd;
		endfunction

		function int pending();
			return tag_q.size();
		endfunction

		function void note_input(logic [63:0] w, logic [3:0] nb_in, logic last);
			logic [3:0]  nb;
			logic [63:0] blk;
			tag_t        t;
			if (!open) begin
				va = sip_pkg::INIT_A ^ key_lo;
				vb = sip_pkg::INIT_B ^ key_hi;
				vc = sip_pkg::INIT_C ^ key_lo;
				vd = sip_pkg::INIT_D ^ key_hi;
				if (wide)
					vb ^= {56'd0, sip_pkg::WIDE_MARK};
				len  = '0;
				open = 1'b1;
			end
			if (!last) begin
				absorb(w);
				len = len + 8'd8;
				return;
			end
			nb = (nb_in > 4'd8) ? 4'd8 : nb_in;
			if (nb == 4'd8) begin
				absorb(w);
				len = len + 8'd8;
				blk = {len, 56'd0};
			end else begin
				len = len + {4'd0, nb};
				blk = {len, 56'd0} | (w & ((64'd1 << (8 * nb)) - 64'd1));
			end
			absorb(blk);
			vc ^= {56'd0, wide ? sip_pkg::WIDE_MARK : sip_pkg::NARROW_MARK};
			t.word  = squeeze();
			t.index = 1'b0;
			t.last  = !wide;
			tag_q.push_back(t);
			open = 1'b0;
			if (wide) begin
				vb ^= {56'd0, sip_pkg::SECOND_MARK};
				t.word  = squeeze();
				t.index = 1'b1;
				t.last  = 1'b1;
				tag_q.push_back(t);
			end
		endfunction

		function void check_tag(logic [63:0] word, logic index, logic last);
			tag_t t;
			if (tag_q.size() == 0) begin
				report($sformatf("unexpected tag word %h", word));
				return;
			end
			t = tag_q.pop_front();
			if (word !== t.word)
				report($sformatf("tag_word %h, expected %h", word, t.word));
			if (index !== t.index)
				report($sformatf("tag_index %b, expected %b", index, t.index));
			if (last !== t.last)
				report($sformatf("tag_last %b, expected %b", last, t.last));
		endfunction

		function void finish_check();
			if (tag_q.size() != 0)
				report($sformatf("%0d tag words never arrived", tag_q.size()));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [sip_pkg::ADDR_W-1:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // msg_word[63:0], valid_bytes[67:64], zero
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // tag_word[63:0]
	logic        m_tuser;  // tag_index
	logic        m_tlast;

	mac_scoreboard sb;
	int       burst_left = 0;
	int       items_sent = 0;
	int       idle_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_hold = 0;

	siphash_keyed_mac #(
		.COMPRESS_ROUNDS(COMPRESS_ROUNDS),
		.FINAL_ROUNDS(FINAL_ROUNDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tag receiver with its own stall pattern
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_tag(m_tdata, m_tuser, m_tlast);
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= (rx_left % 5 == 0);
			default: begin
				if (rx_hold == 0) begin
					rx_hold = $urandom_range(5, 60);
					m_tready <= 1'b1;
				end else begin
					rx_hold--;
					m_tready <= 1'b0;
				end
			end
		endcase
	end

	// any transfer or register access counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("siphash_keyed_mac regression: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic last);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tdata  <= {4'd0, nb, w};
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(w, nb, last);
		items_sent++;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_message(input int words, input logic [3:0] last_nb);
		for (int i = 1; i < words; i++)
			send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
		send_word(rand_word(), last_nb, 1'b1);
	endtask

	// let every owed tag drain before registers change
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		case ($urandom_range(0, 3))
			0: return 64'd0;
			1: return '1;
			default: return rand_word();
		endcase
	endfunction

	initial begin
		int words;
		int nb;
		sb = new();
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: zero key, wide tag; empty message
		send_word(64'd0, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		settle();

		reg_write(sip_pkg::REG_KEY_LOW, '1);
		reg_write(sip_pkg::REG_KEY_HIGH, '1);
		reg_write(sip_pkg::REG_WIDE_TAG, 64'd0);
		send_word('1, 4'd8, 1'b1);
		send_word('1, 4'd15, 1'b1);
		send_word(64'h5555_5555_5555_5555, 4'd3, 1'b1);
		send_word(64'haaaa_aaaa_aaaa_aaaa, 4'd7, 1'b0);
		send_word(64'h0123_4567_89ab_cdef, 4'd9, 1'b1);
		settle();

		reg_write(sip_pkg::REG_WIDE_TAG, 64'd1);
		reg_write(sip_pkg::REG_KEY_LOW, rand_word());
		reg_write(sip_pkg::REG_KEY_HIGH, 64'd0);
		send_word('1, 4'd0, 1'b0);
		send_word(64'd0, 4'd8, 1'b1);
		send_word(rand_word(), 4'd12, 1'b0);
		send_word(rand_word(), 4'd0, 1'b0);
		send_word(rand_word(), 4'd1, 1'b1);
		send_word(rand_word(), 4'd4, 1'b1);
		settle();

		reg_write(sip_pkg::REG_KEY_LOW, 64'd0);
		reg_write(sip_pkg::REG_WIDE_TAG, 64'd0);
		send_word(rand_word(), 4'd6, 1'b0);
		send_word(rand_word(), 4'd2, 1'b1);
		send_word(rand_word(), 4'd5, 1'b1);
		settle();

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) != 0)
				reg_write(sip_pkg::REG_KEY_LOW, pick_key());
			if ($urandom_range(0, 2) != 0)
				reg_write(sip_pkg::REG_KEY_HIGH, pick_key());
			reg_write(sip_pkg::REG_WIDE_TAG, {63'd0, 1'($urandom_range(0, 1))});
			repeat ($urandom_range(5, 20)) begin
				case ($urandom_range(0, 19))
					0:       words = $urandom_range(30, 40);  // length can wrap past 255
					1, 2, 3: words = $urandom_range(7, 20);
					default: words = $urandom_range(1, 6);
				endcase
				nb = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
				send_message(words, nb[3:0]);
			end
			settle();
		end

		settle();
		sb.finish_check();
		if (sb.mismatches == 0)
			$display("siphash_keyed_mac regression: pass");
		else
			$display("siphash_keyed_mac regression: fail");
		$finish;
	end

endmodule
